[rtl/swgc_pkg.sv]
// Shared constants, types and helpers of the sliding-window GC content search.
package swgc_pkg;

    // Window storage and count widths
    localparam int MAX_WIN = 4096;
    localparam int PTR_W   = $clog2(MAX_WIN);
    localparam int LEN_W   = PTR_W + 1;

    // Ratio, score and position widths
    localparam int FRAC_W  = 16;
    localparam int Q_W     = FRAC_W + 1;
    localparam int SCORE_W = Q_W + 1;
    localparam int POS_W   = 32;
    localparam int DIVD_W  = LEN_W + FRAC_W;

    // Configuration port
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_N   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_GC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_N      = 3'd4;

    localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 13'd100;
    localparam logic [Q_W-1:0]   TARGET_GC_RST  = 17'd32768;
    localparam logic [Q_W-1:0]   TARGET_N_RST   = 17'd0;
    localparam logic [Q_W-1:0]   TOL_GC_RST     = 17'd655;
    localparam logic [Q_W-1:0]   TOL_N_RST      = 17'd0;

    // Base classes held in the window line
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_GC    = 2'd1;
    localparam logic [1:0] CLS_N     = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_BEST  = 2'd0;
    localparam logic [1:0] STAT_MATCH = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;

    // ASCII codes of interest
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_N = 8'h4E;
    localparam logic [7:0] CHAR_X = 8'h58;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } div_req_t;

    // Map an ASCII base to its class
    function automatic logic [1:0] classify(input logic [7:0] b);
        logic [1:0] cls;
        cls = CLS_OTHER;
        if (b == CHAR_G || b == CHAR_C)
        begin
            cls = CLS_GC;
        end
        else if (b == CHAR_N || b == CHAR_X)
        begin
            cls = CLS_N;
        end
        return cls;
    endfunction

endpackage

[rtl/sliding_window_gc_content_search.sv]
// Top level of the sliding-window GC content search.
//
// Bases enter on the in channel (valid/ready, fields base and last); at most one
// result per base leaves on the out channel (valid/ready, start_pos, gc_ratio,
// n_ratio, status). Registers must be written via cfg_we/cfg_addr/cfg_data only
// while the block is idle; the block does not enforce this. A window_len write
// restarts the stream. Each base is handled by a small sequencer, and in_ready
// stays low until it ends. A base that leaves no usable full window (window not
// yet full, or all N) passes from ST_IDLE through ST_UPD to ST_DONE. Otherwise it
// runs two 17-step divisions on the one shared restoring divider (GC count over
// non-N count, N count over window length). After a match, bases up to the last
// one are dropped at one per cycle. A result is loaded into the output register
// in ST_DONE, and the next base is taken while that result waits. If the receiver
// still holds off the previous result when a new one is ready, the sequencer
// waits and in_ready stays low.
// Reset clears the stream state and loads the register defaults; the window line
// needs no clearing since it is only read once filled. After the last base all
// stream state returns to its reset value.
module sliding_window_gc_content_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      base,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [swgc_pkg::POS_W-1:0]      start_pos,
    output logic [swgc_pkg::Q_W-1:0]        gc_ratio,
    output logic [swgc_pkg::Q_W-1:0]        n_ratio,
    output logic [1:0]                      status,
    input  logic                            cfg_we,
    input  logic [swgc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [swgc_pkg::CFG_W-1:0]      cfg_data
);
    import swgc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_UPD     = 8'b0000_0010,
        ST_GC_GO   = 8'b0000_0100,
        ST_GC_WAIT = 8'b0000_1000,
        ST_N_GO    = 8'b0001_0000,
        ST_N_WAIT  = 8'b0010_0000,
        ST_EVAL    = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [LEN_W-1:0] window_len_reg, window_len_next;
    logic [Q_W-1:0]   target_gc_reg, target_gc_next;
    logic [Q_W-1:0]   target_n_reg, target_n_next;
    logic [Q_W-1:0]   tol_gc_reg, tol_gc_next;
    logic [Q_W-1:0]   tol_n_reg, tol_n_next;

    // Stream state
    logic [LEN_W-1:0]   gc_count_reg, gc_count_next;
    logic [LEN_W-1:0]   n_count_reg, n_count_next;
    logic [POS_W-1:0]   base_index_reg, base_index_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [POS_W-1:0]   best_start_reg, best_start_next;
    logic [Q_W-1:0]     best_gc_reg, best_gc_next;
    logic [Q_W-1:0]     best_n_reg, best_n_next;
    logic               found_reg, found_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               win_full_reg, win_full_next;

    // Per-base working registers
    logic [1:0]       cls_reg, cls_next;
    logic             last_reg, last_next;
    logic             match_reg, match_next;
    logic [Q_W-1:0]   gc_q_reg, gc_q_next;
    logic [Q_W-1:0]   n_q_reg, n_q_next;
    logic [POS_W-1:0] cur_start_reg, cur_start_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic             out_load;
    logic [POS_W-1:0] start_pos_reg, start_pos_next;
    logic [Q_W-1:0]   gc_ratio_reg, gc_ratio_next;
    logic [Q_W-1:0]   n_ratio_reg, n_ratio_next;
    logic [1:0]       status_reg, status_next;

    logic             restart;
    logic [LEN_W-1:0] len;
    logic [PTR_W-1:0] slot;
    logic [LEN_W-1:0] slot_inc;
    logic             wrap;
    logic             ram_we;
    logic [1:0]       ram_rdata;
    logic             gc_dec, gc_inc, n_dec, n_inc;
    logic [LEN_W-1:0] gc_new, n_new;
    logic [Q_W-1:0]   dgc, dn;
    logic [SCORE_W-1:0] score;
    logic             have_res, out_free;
    div_req_t         div_req;
    logic             div_done;
    logic [Q_W-1:0]   div_q;

    // Saturate the window length to 1..MAX_WIN
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (window_len_reg > LEN_W'(MAX_WIN))
        begin
            len = LEN_W'(MAX_WIN);
        end
        else
        begin
            len = window_len_reg;
        end
    end

    // Locate the slot of the outgoing base
    assign slot     = ({1'b0, wr_ptr_reg} < len) ? wr_ptr_reg : '0;
    assign slot_inc = {1'b0, slot} + LEN_W'(1);
    assign wrap     = (slot_inc >= len);

    // Update the window counts with the outgoing and incoming class
    assign gc_dec = win_full_reg && (ram_rdata == CLS_GC) && (gc_count_reg != '0);
    assign n_dec  = win_full_reg && (ram_rdata == CLS_N) && (n_count_reg != '0);
    assign gc_inc = (cls_reg == CLS_GC);
    assign n_inc  = (cls_reg == CLS_N);
    assign gc_new = gc_count_reg - LEN_W'(gc_dec) + LEN_W'(gc_inc);
    assign n_new  = n_count_reg - LEN_W'(n_dec) + LEN_W'(n_inc);

    // Distances to the targets and their sum
    assign dgc   = (gc_q_reg >= target_gc_reg) ? gc_q_reg - target_gc_reg
                                               : target_gc_reg - gc_q_reg;
    assign dn    = (n_q_reg >= target_n_reg) ? n_q_reg - target_n_reg
                                             : target_n_reg - n_q_reg;
    assign score = {1'b0, dgc} + {1'b0, dn};

    assign have_res = match_reg || last_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        target_gc_next  = target_gc_reg;
        target_n_next   = target_n_reg;
        tol_gc_next     = tol_gc_reg;
        tol_n_next      = tol_n_reg;
        gc_count_next   = gc_count_reg;
        n_count_next    = n_count_reg;
        base_index_next = base_index_reg;
        best_score_next = best_score_reg;
        best_start_next = best_start_reg;
        best_gc_next    = best_gc_reg;
        best_n_next     = best_n_reg;
        found_next      = found_reg;
        wr_ptr_next     = wr_ptr_reg;
        win_full_next   = win_full_reg;
        cls_next        = cls_reg;
        last_next       = last_reg;
        match_next      = match_reg;
        gc_q_next       = gc_q_reg;
        n_q_next        = n_q_reg;
        cur_start_next  = cur_start_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_load        = 1'b0;
        start_pos_next  = start_pos_reg;
        gc_ratio_next   = gc_ratio_reg;
        n_ratio_next    = n_ratio_reg;
        status_next     = status_reg;
        restart         = 1'b0;
        ram_we          = 1'b0;
        div_req         = '0;

        // Take register writes
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_WINDOW_LEN:
                begin
                    window_len_next = cfg_data[LEN_W-1:0];
                    restart         = 1'b1;
                end
                REG_TARGET_GC:  target_gc_next = cfg_data[Q_W-1:0];
                REG_TARGET_N:   target_n_next  = cfg_data[Q_W-1:0];
                REG_TOL_GC:     tol_gc_next    = cfg_data[Q_W-1:0];
                REG_TOL_N:      tol_n_next     = cfg_data[Q_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Capture a base; after a match only the last base matters
                if (in_valid)
                begin
                    cls_next   = classify(base);
                    last_next  = last;
                    match_next = 1'b0;
                    if (found_reg)
                    begin
                        restart = last;
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                // Replace the outgoing base and advance the ring
                ram_we          = 1'b1;
                gc_count_next   = gc_new;
                n_count_next    = n_new;
                wr_ptr_next     = wrap ? '0 : slot_inc[PTR_W-1:0];
                win_full_next   = win_full_reg || wrap;
                base_index_next = base_index_reg + POS_W'(1);
                if ((win_full_reg || wrap) && (n_new < len))
                begin
                    state_next = ST_GC_GO;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_GC_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {gc_count_reg, FRAC_W'(0)};
                div_req.divisor  = len - n_count_reg;
                state_next       = ST_GC_WAIT;
            end
            ST_GC_WAIT:
            begin
                if (div_done)
                begin
                    gc_q_next  = div_q;
                    state_next = ST_N_GO;
                end
            end
            ST_N_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {n_count_reg, FRAC_W'(0)};
                div_req.divisor  = len;
                state_next       = ST_N_WAIT;
            end
            ST_N_WAIT:
            begin
                if (div_done)
                begin
                    n_q_next   = div_q;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // Keep the best window and check the tolerances
                cur_start_next = base_index_reg - POS_W'(len);
                if (score < best_score_reg)
                begin
                    best_score_next = score;
                    best_start_next = base_index_reg - POS_W'(len);
                    best_gc_next    = gc_q_reg;
                    best_n_next     = n_q_reg;
                end
                if (dgc <= tol_gc_reg && dn <= tol_n_reg)
                begin
                    found_next = 1'b1;
                    match_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free
                if (!have_res)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (match_reg)
                    begin
                        start_pos_next = cur_start_reg;
                        gc_ratio_next  = gc_q_reg;
                        n_ratio_next   = n_q_reg;
                        status_next    = STAT_MATCH;
                    end
                    else if (!win_full_reg)
                    begin
                        start_pos_next = '0;
                        gc_ratio_next  = '0;
                        n_ratio_next   = '0;
                        status_next    = STAT_SHORT;
                    end
                    else
                    begin
                        start_pos_next = best_start_reg;
                        gc_ratio_next  = best_gc_reg;
                        n_ratio_next   = best_n_reg;
                        status_next    = STAT_BEST;
                    end
                    restart    = last_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop all stream state back to its start
        if (restart)
        begin
            gc_count_next   = '0;
            n_count_next    = '0;
            base_index_next = '0;
            best_score_next = '1;
            best_start_next = '0;
            best_gc_next    = '0;
            best_n_next     = '0;
            found_next      = 1'b0;
            wr_ptr_next     = '0;
            win_full_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= WINDOW_LEN_RST;
            target_gc_reg  <= TARGET_GC_RST;
            target_n_reg   <= TARGET_N_RST;
            tol_gc_reg     <= TOL_GC_RST;
            tol_n_reg      <= TOL_N_RST;
            gc_count_reg   <= '0;
            n_count_reg    <= '0;
            base_index_reg <= '0;
            best_score_reg <= '1;
            best_start_reg <= '0;
            best_gc_reg    <= '0;
            best_n_reg     <= '0;
            found_reg      <= 1'b0;
            wr_ptr_reg     <= '0;
            win_full_reg   <= 1'b0;
            last_reg       <= 1'b0;
            match_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            target_gc_reg  <= target_gc_next;
            target_n_reg   <= target_n_next;
            tol_gc_reg     <= tol_gc_next;
            tol_n_reg      <= tol_n_next;
            gc_count_reg   <= gc_count_next;
            n_count_reg    <= n_count_next;
            base_index_reg <= base_index_next;
            best_score_reg <= best_score_next;
            best_start_reg <= best_start_next;
            best_gc_reg    <= best_gc_next;
            best_n_reg     <= best_n_next;
            found_reg      <= found_next;
            wr_ptr_reg     <= wr_ptr_next;
            win_full_reg   <= win_full_next;
            last_reg       <= last_next;
            match_reg      <= match_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers hold no reset
    always_ff @(posedge clk)
    begin
        cls_reg       <= cls_next;
        gc_q_reg      <= gc_q_next;
        n_q_reg       <= n_q_next;
        cur_start_reg <= cur_start_next;
        if (out_load)
        begin
            start_pos_reg <= start_pos_next;
            gc_ratio_reg  <= gc_ratio_next;
            n_ratio_reg   <= n_ratio_next;
            status_reg    <= status_next;
        end
    end

    // Window line of base classes, read every cycle at the current slot
    swgc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIN)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (cls_reg),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    swgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid = out_valid_reg;
    assign start_pos = start_pos_reg;
    assign gc_ratio  = gc_ratio_reg;
    assign n_ratio   = n_ratio_reg;
    assign status    = status_reg;

endmodule

[rtl/swgc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swgc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/swgc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by both ratio divisions.
module swgc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swgc_pkg::div_req_t      req,
    output logic                    done,
    output logic [swgc_pkg::Q_W-1:0] quotient
);
    import swgc_pkg::*;

    localparam int REM_W  = PTR_W;
    localparam int STEP_W = $clog2(Q_W + 1);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    sh_reg, sh_next;
    logic [LEN_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [LEN_W-1:0]  trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, sh_reg[Q_W-1]};
    assign fits  = (trial >= div_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // Quotient fits Q_W bits, so the upper dividend bits start below the divisor
            rem_next  = req.dividend[DIVD_W-1:Q_W];
            sh_next   = req.dividend[Q_W-1:0];
            div_next  = req.divisor;
            cnt_next  = STEP_W'(Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? REM_W'(trial - div_reg) : trial[REM_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath holds no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

[rtl/swgc_check.sv]
// Port-level checker of the GC content search, bound to the top level.
module swgc_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [swgc_pkg::POS_W-1:0] start_pos,
    input logic [swgc_pkg::Q_W-1:0]   gc_ratio,
    input logic [swgc_pkg::Q_W-1:0]   n_ratio,
    input logic [1:0]                 status
);
    import swgc_pkg::*;

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_pos) && $stable(status)
            && $stable(gc_ratio) && $stable(n_ratio))
        else $error("result changed while stalled");

    // A short stream reports zero fields
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_SHORT |-> start_pos == '0 && gc_ratio == '0
            && n_ratio == '0)
        else $error("short stream result carries nonzero fields");

    // Ratios never exceed one in Q1.16
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!gc_ratio[Q_W-1] || gc_ratio[Q_W-2:0] == '0)
            && (!n_ratio[Q_W-1] || n_ratio[Q_W-2:0] == '0))
        else $error("ratio above one");

    // A matched window is never made entirely of N
    a_match_not_all_n: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_MATCH |-> !n_ratio[Q_W-1])
        else $error("all-N window reported as match");

endmodule

bind sliding_window_gc_content_search swgc_check u_swgc_check (.*);
